// File: hdl/ssde_pkg.sv
// Shared widths and types for the sliding-window deviation core.
`default_nettype none
package ssde_pkg;

  // Sample, deviation and tolerance are all unsigned Q4.12.
  localparam int SAMPW = 16;
  localparam int DEVW  = 16;
  localparam int SQW   = 2 * SAMPW;

  // The variance is below 2^30 because the deviation is below 2^15.
  localparam int VARW      = 30;
  localparam int CNTW      = 5;

  typedef logic [SAMPW-1:0] sample_t;
  typedef logic [DEVW-1:0]  dev_t;
  typedef logic [CNTW-1:0]  cnt_t;

endpackage
`default_nettype wire

// File: hdl/ssde_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module ssde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/sliding_stddev_equilibrium_core.sv
// Top level: sliding-window standard deviation with an equilibrium flag.
// Each input transaction carries one Q4.12 sample that replaces the oldest entry of a
// WINDOW_LEN-deep ring held in a RAM; the ring reads as zeros after reset. Running sums of
// the samples and of their squares give the population deviation
// isqrt(floor((N*S2 - S1^2)/N^2)), and in_equilibrium is set when the deviation moved by
// less than the tolerance since the previous sample. One item is processed at a time; no new
// sample is accepted until the last one is through. With WINDOW_LEN a power of two an item
// passes through the accepting cycle, the RAM read, the sum update, the product and operand
// stages, the bit-pair square root unit (15 steps) and the output stage. For other window
// lengths the root is taken over the whole numerator in 16+ceil(log2(WINDOW_LEN)) steps and
// one more stage scales it by 1/N. The output stage waits while an earlier result is still
// held. A finished result waits in the output register while the next sample is accepted.
// No clearing pass is needed after reset.
`default_nettype none
module sliding_stddev_equilibrium_core #(
  parameter int WINDOW_LEN = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ssde_pkg::DEVW-1:0]  cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [ssde_pkg::SAMPW-1:0] sample_q12,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            in_equilibrium,
  output logic      [ssde_pkg::DEVW-1:0]  std_dev_q12
);

  localparam int LN   = $clog2(WINDOW_LEN);
  localparam int AW   = (LN < 1) ? 1 : LN;
  localparam int S1W  = ssde_pkg::SAMPW + LN;
  localparam int S2W  = ssde_pkg::SQW + LN;
  localparam int PW   = ssde_pkg::SQW + 2 * LN;
  localparam int SH   = 2 * LN;
  localparam bit IS_POW2 = (WINDOW_LEN == (1 << LN));
  localparam int QW     = IS_POW2 ? ssde_pkg::VARW : PW;
  localparam int QSTEPS = QW / 2;
  localparam int RQW    = PW / 2;
  localparam int RK     = RQW + LN;
  localparam int MW     = RK - LN + 2;
  localparam int SCW    = RQW + MW;
  // Rounded-up reciprocal of N; exact floor division for any root below 2^RQW.
  localparam longint unsigned RECIP = ((64'd1 << RK) + WINDOW_LEN - 1) / WINDOW_LEN;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_NUM  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_SQRT = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                    state;
  logic [AW-1:0]                 wp;
  logic [WINDOW_LEN-1:0]         filled;
  logic [S1W-1:0]                s1;
  logic [S2W-1:0]                s2;
  ssde_pkg::dev_t                prev_dev;
  ssde_pkg::dev_t                tolerance;
  ssde_pkg::sample_t             sample_reg;
  ssde_pkg::sample_t             old_reg;
  logic [ssde_pkg::SQW-1:0]      old_sq;
  logic [ssde_pkg::SQW-1:0]      new_sq;
  logic [PW-1:0]                 prod_s1;
  logic [PW-1:0]                 prod_n;
  logic [QW-1:0]                 sq_v;
  logic [QW-1:0]                 sq_root;
  logic [QW-1:0]                 sq_bit;
  ssde_pkg::cnt_t                cnt;

  ssde_pkg::sample_t             ram_rdata;
  ssde_pkg::sample_t             old_val;
  logic [PW-1:0]                 num;
  logic [SCW-1:0]                scaled;
  logic [QW-1:0]                 sq_trial;
  logic                          sq_ge;
  ssde_pkg::dev_t                dev;
  ssde_pkg::dev_t                diff;
  logic                          out_free;

  ssde_ram #(
    .WIDTH(ssde_pkg::SAMPW),
    .DEPTH(WINDOW_LEN)
  ) u_window (
    .clk  (clk),
    .we   (state == S_READ),
    .waddr(wp),
    .wdata(sample_reg),
    .raddr(wp),
    .rdata(ram_rdata)
  );

  always_comb begin
    in_ready = (state == S_IDLE);
    out_free = !out_valid || out_ready;
    // Entries never written since reset stand for zero samples.
    old_val = filled[wp] ? ram_rdata : '0;
    num = prod_n - prod_s1;

    // floor(isqrt(x)/N) equals isqrt(floor(x/N^2)), so the root is scaled by 1/N.
    scaled = SCW'(sq_root[RQW-1:0]) * SCW'(RECIP);

    sq_trial = sq_root + sq_bit;
    sq_ge    = (sq_v >= sq_trial);

    dev  = sq_root[ssde_pkg::DEVW-1:0];
    diff = (dev >= prev_dev) ? dev - prev_dev : prev_dev - dev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      filled    <= '0;
      s1        <= '0;
      s2        <= '0;
      prev_dev  <= '0;
      tolerance <= ssde_pkg::DEVW'(4096);
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tolerance <= cfg_wr_data;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sample_reg <= sample_q12;
            state      <= S_READ;
          end
        end
        S_READ: begin
          old_reg    <= old_val;
          old_sq     <= ssde_pkg::SQW'(old_val) * ssde_pkg::SQW'(old_val);
          new_sq     <= ssde_pkg::SQW'(sample_reg) * ssde_pkg::SQW'(sample_reg);
          filled[wp] <= 1'b1;
          state      <= S_SUM;
        end
        S_SUM: begin
          s1 <= s1 - S1W'(old_reg) + S1W'(sample_reg);
          s2 <= s2 - S2W'(old_sq) + S2W'(new_sq);
          wp <= (wp == AW'(WINDOW_LEN - 1)) ? '0 : wp + AW'(1);
          state <= S_MUL;
        end
        S_MUL: begin
          prod_s1 <= PW'(s1) * PW'(s1);
          prod_n  <= PW'(s2) * PW'(WINDOW_LEN);
          state   <= S_NUM;
        end
        S_NUM: begin
          cnt     <= '0;
          sq_root <= '0;
          sq_bit  <= QW'(1) << (QW - 2);
          // With N a power of two the division by N^2 is a shift; otherwise the root
          // of the whole numerator is taken and divided by N afterwards.
          sq_v    <= IS_POW2 ? QW'(num >> SH) : QW'(num);
          state   <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_v    <= sq_v - sq_trial;
            sq_root <= (sq_root >> 1) + sq_bit;
          end else begin
            sq_root <= sq_root >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + ssde_pkg::CNTW'(1);
          if (cnt == ssde_pkg::CNTW'(QSTEPS - 1)) begin
            state <= IS_POW2 ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          sq_root <= QW'(scaled[RK +: ssde_pkg::DEVW]);
          state   <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            in_equilibrium <= (diff < tolerance);
            std_dev_q12    <= dev;
            prev_dev       <= dev;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
